// ----- hw/rtl/i2ccr_pkg.sv -----
// Shared types, codes and constants for the serial-command to I2C master relay.
// No dependencies; imported by i2ccr_step and i2c_command_relay_master.
package i2ccr_pkg;

  // Sizing
  localparam int BUFFER_DEPTH = 100;  // transmit buffer length, last index stops a write
  localparam int READ_COUNT   = 10;   // bytes read per read transfer
  localparam int WR_IDX_W     = 7;
  localparam int RD_CNT_W     = 4;
  localparam int ADDR_W       = 7;
  localparam int CFG_DATA_W   = 7;

  localparam logic [WR_IDX_W-1:0] WR_IDX_LAST = WR_IDX_W'(BUFFER_DEPTH - 1);
  localparam logic [RD_CNT_W-1:0] RD_CNT_MAX  = RD_CNT_W'(READ_COUNT);

  // Input operation
  localparam logic OP_HOST = 1'b0;
  localparam logic OP_BUS  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_SLAVE_ADDR = 1'b0;
  localparam logic CFG_ACK_CMD    = 1'b1;

  // Bus status codes, hardware status divided by eight
  localparam logic [4:0] TWI_START     = 5'd1;   // 0x08 start sent
  localparam logic [4:0] TWI_SLAW_ACK  = 5'd3;   // 0x18
  localparam logic [4:0] TWI_DATA_ACK  = 5'd5;   // 0x28
  localparam logic [4:0] TWI_DATA_NACK = 5'd6;   // 0x30
  localparam logic [4:0] TWI_SLAR_ACK  = 5'd8;   // 0x40
  localparam logic [4:0] TWI_RX_ACK    = 5'd10;  // 0x50 data received
  localparam logic [4:0] TWI_RX_NACK   = 5'd11;  // 0x58

  // Host command characters
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_W = 8'h77;
  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_Q = 8'h71;
  localparam logic [7:0] CH_S = 8'h73;
  localparam logic [7:0] CH_1 = 8'h31;
  localparam logic [7:0] CH_2 = 8'h32;
  localparam logic [7:0] CH_3 = 8'h33;
  localparam logic [7:0] CH_X = 8'h78;
  localparam logic [7:0] CH_P = 8'h70;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_ACK   = 3'd2,
    ACT_NACK  = 3'd3,
    ACT_STOP  = 3'd4
  } bus_act_t;

  typedef enum logic [1:0] {
    BEEP_SAME = 2'd0,
    BEEP_ON   = 2'd1,
    BEEP_OFF  = 2'd2
  } beep_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] host_byte;
    logic [4:0] bus_status;
    logic [7:0] rx_data;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] slave_address;
    logic              ack_after_command;
  } cfg_t;

  typedef struct packed {
    logic [7:0]          cmd;
    logic [WR_IDX_W-1:0] wr_idx;
    logic [RD_CNT_W-1:0] rd_cnt;
    logic                rd_dir;
    logic                print;
  } state_t;

  typedef struct packed {
    bus_act_t   bus_action;
    logic       data_valid;
    logic [7:0] data_out;
    logic       host_tx_valid;
    logic [7:0] host_tx_byte;
    beep_t      beeper_action;
    logic       print_enable;
  } result_t;

endpackage

// ----- hw/rtl/i2ccr_step.sv -----
// Per-item decision logic: next relay state and the result for one request.
// Depends on i2ccr_pkg.
module i2ccr_step import i2ccr_pkg::*; (
  input  item_t   item,
  input  cfg_t    cfg,
  input  state_t  cur,
  output state_t  nxt,
  output result_t res
);

  logic [WR_IDX_W-1:0] wr_idx_inc;
  logic [RD_CNT_W-1:0] rd_cnt_inc;
  logic [7:0]          cur_entry;

  assign wr_idx_inc = cur.wr_idx + 1'b1;
  assign rd_cnt_inc = cur.rd_cnt + 1'b1;
  // Buffer holds the command at index 0 and zeros elsewhere
  assign cur_entry  = (cur.wr_idx == '0) ? cur.cmd : 8'h00;

  always_comb begin
    nxt = cur;
    res = '0;
    res.bus_action    = ACT_NONE;
    res.beeper_action = BEEP_SAME;

    if (item.operation == OP_HOST) begin
      // Host command byte; read direction always cleared first
      nxt.rd_dir = 1'b0;
      case (item.host_byte) inside
        CH_A, CH_W, CH_D, CH_Q, CH_S, CH_1, CH_2, CH_3: begin
          nxt.cmd        = item.host_byte;
          nxt.wr_idx     = '0;
          res.bus_action = ACT_START;
          if (item.host_byte == CH_S) begin
            res.beeper_action = BEEP_ON;
          end else if (item.host_byte != CH_1 && item.host_byte != CH_2 &&
                       item.host_byte != CH_3) begin
            res.beeper_action = BEEP_OFF;
          end
        end
        CH_X: begin
          nxt.rd_dir     = 1'b1;
          res.bus_action = ACT_START;
        end
        CH_P: begin
          nxt.print = ~cur.print;
        end
        default: begin
        end
      endcase
    end else begin
      // Bus status event
      case (item.bus_status)
        TWI_START: begin
          res.data_valid = 1'b1;
          res.data_out   = {cfg.slave_address, cur.rd_dir};
          res.bus_action = ACT_ACK;
        end
        TWI_SLAW_ACK: begin
          res.data_valid = 1'b1;
          res.data_out   = cur.cmd;
          res.bus_action = cfg.ack_after_command ? ACT_ACK : ACT_NACK;
        end
        TWI_DATA_ACK: begin
          if (cur.wr_idx == WR_IDX_LAST || cur_entry == 8'h00) begin
            res.bus_action = ACT_STOP;
          end else begin
            nxt.wr_idx     = wr_idx_inc;
            res.data_valid = 1'b1;
            res.data_out   = (wr_idx_inc == '0) ? cur.cmd : 8'h00;
            res.bus_action = ACT_ACK;
          end
        end
        TWI_DATA_NACK, TWI_RX_NACK: begin
          res.bus_action = ACT_STOP;
        end
        TWI_SLAR_ACK: begin
          res.bus_action = ACT_ACK;
        end
        TWI_RX_ACK: begin
          res.host_tx_valid = 1'b1;
          res.host_tx_byte  = item.rx_data;
          if (rd_cnt_inc < RD_CNT_MAX) begin
            nxt.rd_cnt     = rd_cnt_inc;
            res.bus_action = ACT_ACK;
          end else begin
            nxt.rd_cnt     = '0;
            res.bus_action = ACT_NACK;
          end
        end
        default: begin
        end
      endcase
    end

    res.print_enable = nxt.print;
  end

endmodule

// ----- hw/rtl/i2c_command_relay_master.sv -----
// Top level of the serial-command to I2C master relay.
// Depends on i2ccr_pkg and i2ccr_step.
//
// Usage:
//   Input channel (in_*): one request per host command byte (operation 0) or
//   per bus status event (operation 1). Output channel (out_*): exactly one
//   result per request, in order, giving the bus action, a byte to load into
//   the bus data register, a byte to echo to the host, a beeper action and the
//   print flag.
//   Configuration (cfg_*): slave address (index 0) and ack-after-command
//   (index 1), written while no request is in flight.
//   The input register loads at the accepting edge and the result register
//   loads from it once the result register is free. Throughput: one request per
//   cycle while the receiver does not stall, set by the single decision stage
//   that updates the relay state.
//   Reset (rst_n low, synchronous) empties both stages, clears the relay
//   state and loads the register reset values.
//   When the receiver stalls, the result holds; the input register still
//   takes one more request, after which in_stall rises until the result moves.
module i2c_command_relay_master import i2ccr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_operation,
  input  logic [7:0]            in_host_byte,
  input  logic [4:0]            in_bus_status,
  input  logic [7:0]            in_rx_data,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_bus_action,
  output logic                  out_data_valid,
  output logic [7:0]            out_data_out,
  output logic                  out_host_tx_valid,
  output logic [7:0]            out_host_tx_byte,
  output logic [1:0]            out_beeper_action,
  output logic                  out_print_enable
);

  cfg_t    cfg_r;
  item_t   item_r;
  logic    in_vld_r;
  state_t  state_r, state_nxt;
  result_t res_r, res_nxt;
  logic    out_vld_r;
  logic    res_adv;
  logic    in_fire;

  // Handshake: result register frees when empty or being taken
  assign res_adv  = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !res_adv;
  assign in_fire  = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slave_address     <= ADDR_W'(56);
      cfg_r.ack_after_command <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLAVE_ADDR: cfg_r.slave_address     <= cfg_data[ADDR_W-1:0];
        CFG_ACK_CMD:    cfg_r.ack_after_command <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_fire) begin
      in_vld_r <= 1'b1;
    end else if (res_adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= '{operation: in_operation, host_byte: in_host_byte,
                  bus_status: in_bus_status, rx_data: in_rx_data};
    end
  end

  // Decision logic
  i2ccr_step u_step (
    .item (item_r),
    .cfg  (cfg_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // Relay state commits as the request moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_vld_r && res_adv) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r && res_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_bus_action    = res_r.bus_action;
  assign out_data_valid    = res_r.data_valid;
  assign out_data_out      = res_r.data_out;
  assign out_host_tx_valid = res_r.host_tx_valid;
  assign out_host_tx_byte  = res_r.host_tx_byte;
  assign out_beeper_action = res_r.beeper_action;
  assign out_print_enable  = res_r.print_enable;

  // Checks
  a_rd_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.rd_cnt < RD_CNT_MAX)
    else $error("read count reached its limit");

  a_wr_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.wr_idx <= WR_IDX_W'(1))
    else $error("write index moved past the first zero entry");

  a_load_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (res_r.data_valid || res_r.host_tx_valid) |->
      (res_r.bus_action == ACT_ACK || res_r.bus_action == ACT_NACK))
    else $error("byte moved without a continue action");

  a_beep_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.beeper_action != BEEP_SAME |->
      res_r.bus_action == ACT_START)
    else $error("beeper change without a bus start");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_vld_r && $stable(item_r))
    else $error("buffered request lost while stalled");

endmodule

// ----- bench/i2c_command_relay_master_tb.sv -----
// Self-checking bench for the serial-command to I2C master relay.
// Drives host bytes and bus status events, predicts each result in step with the RTL.
// Depends on i2ccr_pkg and i2c_command_relay_master.
`timescale 1ns / 1ps

module i2c_command_relay_master_tb;
  import i2ccr_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_PRINTED  = 40;

  logic                  clk;
  logic                  rst_n         = 1'b0;
  logic                  cfg_we        = 1'b0;
  logic                  cfg_index     = CFG_SLAVE_ADDR;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic                  in_operation  = OP_HOST;
  logic [7:0]            in_host_byte  = 8'h00;
  logic [4:0]            in_bus_status = 5'd0;
  logic [7:0]            in_rx_data    = 8'h00;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic [2:0]            out_bus_action;
  logic                  out_data_valid;
  logic [7:0]            out_data_out;
  logic                  out_host_tx_valid;
  logic [7:0]            out_host_tx_byte;
  logic [1:0]            out_beeper_action;
  logic                  out_print_enable;

  // Relay state and registers as the bench expects them
  logic [7:0]          exp_cmd;
  logic [WR_IDX_W-1:0] exp_wr_idx;
  logic [RD_CNT_W-1:0] exp_rd_cnt;
  logic                exp_rd_dir;
  logic                exp_print;
  logic [ADDR_W-1:0]   exp_slave_addr;
  logic                exp_ack_cmd;

  result_t pending_results[$];
  int      requests_sent = 0;
  int      results_seen  = 0;
  int      error_count   = 0;
  int      cycle_count   = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;

  i2c_command_relay_master dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_host_byte     (in_host_byte),
    .in_bus_status    (in_bus_status),
    .in_rx_data       (in_rx_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bus_action   (out_bus_action),
    .out_data_valid   (out_data_valid),
    .out_data_out     (out_data_out),
    .out_host_tx_valid(out_host_tx_valid),
    .out_host_tx_byte (out_host_tx_byte),
    .out_beeper_action(out_beeper_action),
    .out_print_enable (out_print_enable)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("i2c_command_relay_master_tb NOT OK");
      $finish;
    end
  end

  // Random backpressure on the result side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Relay decision for one request; advances the expected state
  function automatic result_t relay_decide(input item_t req);
    result_t r;
    logic    store_cmd;
    r = '0;
    store_cmd = 1'b0;
    r.bus_action = ACT_NONE;
    r.beeper_action = BEEP_SAME;
    if (req.operation == OP_HOST) begin
      exp_rd_dir = 1'b0;
      case (req.host_byte)
        CH_A, CH_W, CH_D, CH_Q: begin
          store_cmd = 1'b1;
          r.beeper_action = BEEP_OFF;
        end
        CH_S: begin
          store_cmd = 1'b1;
          r.beeper_action = BEEP_ON;
        end
        CH_1, CH_2, CH_3: store_cmd = 1'b1;
        CH_X: begin
          exp_rd_dir = 1'b1;
          r.bus_action = ACT_START;
        end
        CH_P: exp_print = ~exp_print;
        default: ;
      endcase
      if (store_cmd) begin
        exp_cmd = req.host_byte;
        exp_wr_idx = '0;
        r.bus_action = ACT_START;
      end
    end else begin
      case (req.bus_status)
        TWI_START: begin
          r.data_valid = 1'b1;
          r.data_out = {exp_slave_addr, exp_rd_dir};
          r.bus_action = ACT_ACK;
        end
        TWI_SLAW_ACK: begin
          r.data_valid = 1'b1;
          r.data_out = exp_cmd;
          if (exp_ack_cmd) r.bus_action = ACT_ACK;
          else r.bus_action = ACT_NACK;
        end
        TWI_DATA_ACK: begin
          // buffer is the command at index 0, zeros after it
          if (exp_wr_idx == WR_IDX_LAST ||
              ((exp_wr_idx == '0) ? exp_cmd : 8'h00) == 8'h00) begin
            r.bus_action = ACT_STOP;
          end else begin
            exp_wr_idx = exp_wr_idx + 1'b1;
            r.data_valid = 1'b1;
            r.data_out = (exp_wr_idx == '0) ? exp_cmd : 8'h00;
            r.bus_action = ACT_ACK;
          end
        end
        TWI_DATA_NACK, TWI_RX_NACK: r.bus_action = ACT_STOP;
        TWI_SLAR_ACK: r.bus_action = ACT_ACK;
        TWI_RX_ACK: begin
          r.host_tx_valid = 1'b1;
          r.host_tx_byte = req.rx_data;
          exp_rd_cnt = exp_rd_cnt + 1'b1;
          if (exp_rd_cnt < RD_CNT_MAX) begin
            r.bus_action = ACT_ACK;
          end else begin
            r.bus_action = ACT_NACK;
            exp_rd_cnt = '0;
          end
        end
        default: ;
      endcase
    end
    r.print_enable = exp_print;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (error_count < MAX_PRINTED)
      $display("ERROR: result %0d %s: got %h, expected %h", results_seen, what, got, want);
    error_count++;
  endtask

  // Result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = result_t'({out_bus_action, out_data_valid, out_data_out, out_host_tx_valid,
                       out_host_tx_byte, out_beeper_action, out_print_enable});
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected, bus_action", 8'(got.bus_action), 8'h00);
      end else begin
        want = pending_results.pop_front();
        if (got.bus_action !== want.bus_action)
          report_mismatch("bus_action", 8'(got.bus_action), 8'(want.bus_action));
        if (got.data_valid !== want.data_valid)
          report_mismatch("data_valid", 8'(got.data_valid), 8'(want.data_valid));
        if (got.data_out !== want.data_out)
          report_mismatch("data_out", got.data_out, want.data_out);
        if (got.host_tx_valid !== want.host_tx_valid)
          report_mismatch("host_tx_valid", 8'(got.host_tx_valid),
                          8'(want.host_tx_valid));
        if (got.host_tx_byte !== want.host_tx_byte)
          report_mismatch("host_tx_byte", got.host_tx_byte, want.host_tx_byte);
        if (got.beeper_action !== want.beeper_action)
          report_mismatch("beeper_action", 8'(got.beeper_action),
                          8'(want.beeper_action));
        if (got.print_enable !== want.print_enable)
          report_mismatch("print_enable", 8'(got.print_enable),
                          8'(want.print_enable));
      end
      results_seen++;
    end
  end

  // One request through the handshake, with a random gap ahead of it
  task automatic send_request(input logic op, input logic [7:0] hb,
                              input logic [4:0] st, input logic [7:0] rx);
    int    gap;
    item_t req;
    gap = 0;
    while (gap < 8 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_host_byte  <= hb;
    in_bus_status <= st;
    in_rx_data    <= rx;
    do @(posedge clk); while (in_stall);
    req.operation  = op;
    req.host_byte  = hb;
    req.bus_status = st;
    req.rx_data    = rx;
    pending_results.push_back(relay_decide(req));
    requests_sent++;
  endtask

  task automatic send_host(input logic [7:0] hb);
    send_request(OP_HOST, hb, 5'($urandom), 8'($urandom));
  endtask

  task automatic send_bus(input logic [4:0] st, input logic [7:0] rx);
    send_request(OP_BUS, 8'($urandom), st, rx);
  endtask

  // Hold off the sender until every result is back
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Both registers, written back to back while idle
  task automatic load_registers(input logic [ADDR_W-1:0] addr, input logic ack);
    wait_until_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLAVE_ADDR;
    cfg_data  <= CFG_DATA_W'(addr);
    @(posedge clk);
    cfg_index <= CFG_ACK_CMD;
    cfg_data  <= CFG_DATA_W'(ack);
    @(posedge clk);
    cfg_we <= 1'b0;
    exp_slave_addr = addr;
    exp_ack_cmd = ack;
  endtask

  function automatic logic [7:0] pick_write_cmd();
    case ($urandom_range(0, 7))
      0: return CH_A;
      1: return CH_W;
      2: return CH_D;
      3: return CH_Q;
      4: return CH_S;
      5: return CH_1;
      6: return CH_2;
      default: return CH_3;
    endcase
  endfunction

  function automatic logic [7:0] pick_host_byte();
    case ($urandom_range(0, 3))
      0: return CH_X;
      1: return CH_P;
      2: return pick_write_cmd();
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [4:0] pick_status();
    case ($urandom_range(0, 8))
      0: return TWI_START;
      1: return TWI_SLAW_ACK;
      2: return TWI_DATA_ACK;
      3: return TWI_DATA_NACK;
      4: return TWI_SLAR_ACK;
      5: return TWI_RX_ACK;
      6: return TWI_RX_NACK;
      default: return 5'($urandom);
    endcase
  endfunction

  // Reset contents: empty command, default address, print flag toggling
  task automatic test_reset_values();
    send_bus(TWI_SLAW_ACK, 8'h00);
    send_bus(TWI_DATA_ACK, 8'hFF);
    send_bus(TWI_START, 8'h00);
    send_host(CH_P);
    send_host(CH_X);
  endtask

  // The write commands other than s, plus unknown bytes at both ends of the range
  task automatic test_command_set();
    send_host(CH_A);
    send_host(CH_W);
    send_host(CH_D);
    send_host(CH_Q);
    send_host(CH_1);
    send_host(CH_2);
    send_host(CH_3);
    send_host(8'h00);
    send_host(8'hFF);
  endtask

  // Full write transfer: address, command, trailing zero, then stop
  task automatic test_write_transfer();
    send_host(CH_S);
    send_bus(TWI_START, 8'h00);
    send_bus(TWI_SLAW_ACK, 8'h00);
    send_bus(TWI_DATA_ACK, 8'h00);
    send_bus(TWI_DATA_ACK, 8'h00);
    send_bus(TWI_DATA_NACK, 8'h00);
  endtask

  // Address and ack setting at their extremes
  task automatic test_register_extremes();
    load_registers(7'h7F, 1'b1);
    send_host(CH_X);
    send_bus(TWI_START, 8'h00);
    send_host(CH_1);
    send_bus(TWI_SLAW_ACK, 8'h00);
    load_registers(7'h00, 1'b0);
    send_bus(TWI_START, 8'h00);
  endtask

  // Mostly well-formed transfers with random content, some noise
  task automatic test_random_traffic(input int target, input int send_pct,
                                     input int recv_pct);
    int last;
    int pick;
    int n;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    last = requests_sent + target;
    while (requests_sent < last) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // write transfer
        send_host(pick_write_cmd());
        send_bus(TWI_START, 8'($urandom));
        send_bus(TWI_SLAW_ACK, 8'($urandom));
        n = $urandom_range(0, 3);
        repeat (n) send_bus(TWI_DATA_ACK, 8'($urandom));
        if ($urandom_range(0, 1)) send_bus(TWI_DATA_NACK, 8'($urandom));
      end else if (pick < 70) begin
        // read transfer, byte count not always READ_COUNT
        send_host(CH_X);
        send_bus(TWI_START, 8'($urandom));
        send_bus(TWI_SLAR_ACK, 8'($urandom));
        n = $urandom_range(1, READ_COUNT + 3);
        repeat (n) send_bus(TWI_RX_ACK, 8'($urandom));
        send_bus(TWI_RX_NACK, 8'($urandom));
      end else if (pick < 99) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          if ($urandom_range(0, 1)) send_host(pick_host_byte());
          else send_bus(pick_status(), 8'($urandom));
        end
      end else begin
        wait_until_drained();
      end
    end
  endtask

  initial begin
    exp_cmd = '0;
    exp_wr_idx = '0;
    exp_rd_cnt = '0;
    exp_rd_dir = 1'b0;
    exp_print = 1'b0;
    exp_slave_addr = ADDR_W'(56);
    exp_ack_cmd = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_command_set();
    test_write_transfer();
    test_register_extremes();

    load_registers(ADDR_W'($urandom), 1'b1);
    test_random_traffic(360, 22, 49);
    load_registers(7'h7F, 1'b0);
    test_random_traffic(360, 49, 22);
    load_registers(ADDR_W'($urandom), 1'($urandom));
    test_random_traffic(360, 0, 0);

    wait_until_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("i2c_command_relay_master_tb OK");
    else
      $display("i2c_command_relay_master_tb NOT OK");
    $finish;
  end

endmodule

// ----- i2c_command_relay_master.f -----
hw/rtl/i2ccr_pkg.sv
hw/rtl/i2ccr_step.sv
hw/rtl/i2c_command_relay_master.sv
bench/i2c_command_relay_master_tb.sv
